// ===== hw/rtl/mtvp_pkg.sv =====
package mtvp_pkg;

    // Entry list limit and the mark that stands for "no position recorded".
    localparam logic [7:0] MAX_ENTRIES = 8'd255;
    localparam logic [7:0] NO_MARK     = 8'd255;

    // Saturation limit of the decimal accumulator and the flip mask.
    localparam logic [30:0] MAG_SAT  = 31'h7FFF_FFFF;
    localparam logic [31:0] FLIP_BIT = 32'h4000_0000;

    // Character codes that the parser recognises.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_MIN_VALUE   = 2'd0;
    localparam logic [1:0] REG_MAX_VALUE   = 2'd1;
    localparam logic [1:0] REG_FLIP_ENABLE = 2'd2;

    // Result kinds.
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Depth of the queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register values as seen by the datapath.
    typedef struct packed {
        logic [31:0] min_value;
        logic [31:0] max_value;
        logic        flip_enable;
    } t_cfg;

    // Work for the back part caused by one accepted item: at most one
    // number followed by at most one summary.
    typedef struct packed {
        logic        has_num;
        logic        neg;
        logic [30:0] mag;
        logic        flip;
        logic [7:0]  idx;
        logic        has_sum;
        logic [7:0]  cnt;
        logic [7:0]  loop_pos;
        logic [7:0]  rel_pos;
    } t_rec;

endpackage

// ===== hw/rtl/mtvp_fifo.sv =====
module mtvp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtvp_pkg::t_rec    i_data,
    input  logic              i_pop,
    output mtvp_pkg::t_rec    o_head,
    output logic              o_empty,
    output logic              o_full
);

    mtvp_pkg::t_rec                   r_mem [mtvp_pkg::FIFO_DEPTH];
    logic [mtvp_pkg::FIFO_AW-1:0]     r_wr_ptr;
    logic [mtvp_pkg::FIFO_AW-1:0]     r_rd_ptr;
    logic [mtvp_pkg::FIFO_AW:0]       r_level;
    logic [mtvp_pkg::FIFO_AW-1:0]     n_wr_ptr;
    logic [mtvp_pkg::FIFO_AW-1:0]     n_rd_ptr;
    logic [mtvp_pkg::FIFO_AW:0]       n_level;

    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == (mtvp_pkg::FIFO_AW+1)'(mtvp_pkg::FIFO_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and fill level updates; pointers wrap at the power-of-two depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && i_pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Storage needs no reset: an entry is read only after it is written.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/mtvp_front.sv =====
module mtvp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtvp_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_char_valid,
    input  logic              i_end_of_text,
    input  logic              i_full,
    output logic              o_push,
    output mtvp_pkg::t_rec    o_rec
);

    logic [30:0] r_mag;
    logic        r_neg;
    logic        r_has;
    logic        r_flip;
    logic [7:0]  r_count;
    logic [7:0]  r_loop;
    logic [7:0]  r_rel;

    logic [30:0] n_mag;
    logic        n_neg;
    logic        n_has;
    logic        n_flip;
    logic [7:0]  n_count;
    logic [7:0]  n_loop;
    logic [7:0]  n_rel;

    logic        accept;
    logic        take_char;
    logic        is_digit;
    logic        is_delim;
    logic [34:0] mac;
    logic [30:0] mag_sat;
    mtvp_pkg::t_rec rec;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Decimal accumulate: magnitude times ten plus the digit, saturated.
    // The low nibble of an ASCII digit is its value.
    assign mac     = {1'b0, r_mag, 3'b0} + {3'b0, r_mag, 1'b0} + {31'b0, i_char_code[3:0]};
    assign mag_sat = (mac > {4'b0, mtvp_pkg::MAG_SAT}) ? mtvp_pkg::MAG_SAT : mac[30:0];

    assign take_char = i_char_valid && (r_count < mtvp_pkg::MAX_ENTRIES);
    assign is_digit  = i_char_code inside {[mtvp_pkg::CH_ZERO:mtvp_pkg::CH_NINE]};
    assign is_delim  = (i_char_code == mtvp_pkg::CH_SPACE) ||
                       (i_char_code == mtvp_pkg::CH_BAR) ||
                       (i_char_code == mtvp_pkg::CH_SLASH);

    // Classify the character, then apply the end-of-text flush and summary.
    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_has   = r_has;
        n_flip  = r_flip;
        n_count = r_count;
        n_loop  = r_loop;
        n_rel   = r_rel;
        rec     = '0;

        if (take_char) begin
            if (is_digit) begin
                n_mag = mag_sat;
                n_has = 1'b1;
            end else if (i_char_code == mtvp_pkg::CH_MINUS) begin
                if (!r_has) begin
                    n_has = 1'b1;
                    n_neg = 1'b1;
                end
            end else if (i_char_code == mtvp_pkg::CH_AT) begin
                if (i_cfg.flip_enable) begin
                    n_flip = 1'b1;
                end
            end else if (is_delim) begin
                if (r_has) begin
                    rec.has_num = 1'b1;
                    rec.neg     = r_neg;
                    rec.mag     = r_mag;
                    rec.flip    = r_flip;
                    rec.idx     = r_count;
                    n_count     = r_count + 1'b1;
                    n_mag       = '0;
                    n_neg       = 1'b0;
                    n_has       = 1'b0;
                    n_flip      = 1'b0;
                end
                if ((i_char_code == mtvp_pkg::CH_BAR) && (r_loop == mtvp_pkg::NO_MARK)) begin
                    n_loop = n_count;
                end
                if ((i_char_code == mtvp_pkg::CH_SLASH) && (r_rel == mtvp_pkg::NO_MARK)) begin
                    n_rel = n_count;
                end
            end
        end

        if (i_end_of_text) begin
            rec.has_sum  = 1'b1;
            rec.cnt      = n_count;
            rec.loop_pos = n_loop;
            rec.rel_pos  = n_rel;
            if (n_has && (n_count < mtvp_pkg::MAX_ENTRIES)) begin
                rec.has_num = 1'b1;
                rec.neg     = n_neg;
                rec.mag     = n_mag;
                rec.flip    = n_flip;
                rec.idx     = n_count;
                rec.cnt     = n_count + 1'b1;
            end
            n_mag   = '0;
            n_neg   = 1'b0;
            n_has   = 1'b0;
            n_flip  = 1'b0;
            n_count = '0;
            n_loop  = mtvp_pkg::NO_MARK;
            n_rel   = mtvp_pkg::NO_MARK;
        end
    end

    assign o_push = accept && (rec.has_num || rec.has_sum);
    assign o_rec  = rec;

    // Parser state advances only on an input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_has   <= 1'b0;
            r_flip  <= 1'b0;
            r_count <= '0;
            r_loop  <= mtvp_pkg::NO_MARK;
            r_rel   <= mtvp_pkg::NO_MARK;
        end else if (accept) begin
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_has   <= n_has;
            r_flip  <= n_flip;
            r_count <= n_count;
            r_loop  <= n_loop;
            r_rel   <= n_rel;
        end
    end

endmodule

// ===== hw/rtl/mtvp_back.sv =====
module mtvp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtvp_pkg::t_cfg    i_cfg,
    input  logic              i_empty,
    input  mtvp_pkg::t_rec    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [7:0]        o_entry_index,
    output logic [31:0]       o_entry_value,
    output logic [7:0]        o_entry_count,
    output logic [7:0]        o_loop_position,
    output logic [7:0]        o_release_position,
    output logic              o_final_result
);

    logic              r_valid;
    logic              r_num_done;
    logic              r_kind;
    logic [7:0]        r_idx;
    logic [31:0]       r_value;
    logic [7:0]        r_cnt;
    logic [7:0]        r_loop;
    logic [7:0]        r_rel;
    logic              r_final;

    logic              load;
    logic              emit_num;
    logic signed [31:0] raw;
    logic signed [31:0] lo_clamped;
    logic signed [31:0] clamped;
    logic [31:0]       num_value;

    // The output register is free when empty or when its result is taken.
    assign load     = !r_valid || i_ready;
    assign emit_num = i_head.has_num && !r_num_done;

    // Signed value, clamp to the bounds (upper bound wins), optional flip.
    assign raw        = i_head.neg ? -$signed({1'b0, i_head.mag}) : $signed({1'b0, i_head.mag});
    assign lo_clamped = (raw < $signed(i_cfg.min_value)) ? $signed(i_cfg.min_value) : raw;
    assign clamped    = (lo_clamped > $signed(i_cfg.max_value)) ?
                        $signed(i_cfg.max_value) : lo_clamped;
    assign num_value  = i_head.flip ? (clamped ^ mtvp_pkg::FLIP_BIT) : clamped;

    // A record leaves the queue once its last result is loaded.
    assign o_pop = load && !i_empty && !(emit_num && i_head.has_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_num_done <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_num_done <= emit_num && i_head.has_sum;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            if (emit_num) begin
                r_kind  <= mtvp_pkg::KIND_ENTRY;
                r_idx   <= i_head.idx;
                r_value <= num_value;
                r_cnt   <= '0;
                r_loop  <= '0;
                r_rel   <= '0;
                r_final <= !i_head.has_sum;
            end else begin
                r_kind  <= mtvp_pkg::KIND_SUMMARY;
                r_idx   <= '0;
                r_value <= '0;
                r_cnt   <= i_head.cnt;
                r_loop  <= i_head.loop_pos;
                r_rel   <= i_head.rel_pos;
                r_final <= 1'b1;
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_kind             = r_kind;
    assign o_entry_index      = r_idx;
    assign o_entry_value      = r_value;
    assign o_entry_count      = r_cnt;
    assign o_loop_position    = r_loop;
    assign o_release_position = r_rel;
    assign o_final_result     = r_final;

endmodule

// ===== hw/rtl/macro_text_value_parser.sv =====
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_ready   i_char_code, i_char_valid, i_end_of_text
// result   out        o_valid / i_ready   o_kind, o_entry_index, o_entry_value,
//                                         o_entry_count, o_loop_position,
//                                         o_release_position, o_final_result
// config   in         psel/penable/pwrite paddr, pwdata, prdata, pready
//
// One input item is taken per cycle while the queue has room. Any record that it makes is
// written into the queue and then loaded into the output register, where its first result is presented.
// Results leave at one per cycle while i_ready is high, so an end item that flushes a number
// holds the output for both its entry and its summary; the four-entry queue between parser
// and output absorbs this. o_ready falls only while that queue is full, which output stalls
// or a run of end items that each flush a number cause.
// Reset is synchronous and active low and returns parser and registers to defaults.
module macro_text_value_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_char_valid,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_entry_index,
    output logic signed [31:0] o_entry_value,
    output logic [7:0]  o_entry_count,
    output logic [7:0]  o_loop_position,
    output logic [7:0]  o_release_position,
    output logic        o_final_result
);

    mtvp_pkg::t_cfg r_cfg;
    mtvp_pkg::t_rec push_rec;
    mtvp_pkg::t_rec head_rec;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           cfg_wr;
    logic [31:0]    entry_value;

    // Configuration registers, written on the access phase of a write transfer.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value   <= 32'h8000_0000;
            r_cfg.max_value   <= 32'h7FFF_FFFF;
            r_cfg.flip_enable <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                mtvp_pkg::REG_MIN_VALUE:   r_cfg.min_value   <= pwdata;
                mtvp_pkg::REG_MAX_VALUE:   r_cfg.max_value   <= pwdata;
                mtvp_pkg::REG_FLIP_ENABLE: r_cfg.flip_enable <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            mtvp_pkg::REG_MIN_VALUE:   prdata = r_cfg.min_value;
            mtvp_pkg::REG_MAX_VALUE:   prdata = r_cfg.max_value;
            mtvp_pkg::REG_FLIP_ENABLE: prdata = {31'b0, r_cfg.flip_enable};
            default:                   prdata = '0;
        endcase
    end

    mtvp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .i_char_valid  (i_char_valid),
        .i_end_of_text (i_end_of_text),
        .i_full        (q_full),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    mtvp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_rec),
        .i_pop   (pop),
        .o_head  (head_rec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mtvp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_empty            (q_empty),
        .i_head             (head_rec),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_entry_index      (o_entry_index),
        .o_entry_value      (entry_value),
        .o_entry_count      (o_entry_count),
        .o_loop_position    (o_loop_position),
        .o_release_position (o_release_position),
        .o_final_result     (o_final_result)
    );

    assign o_entry_value = $signed(entry_value);

endmodule

// ===== verif/macro_text_value_parser_tb.sv =====
module macro_text_value_parser_tb;

    // One character item of the macro text, as offered on the input channel.
    typedef struct packed {
        logic [7:0] code;
        logic       valid;
        logic       eot;
    } t_text_char;

    // One result as it should leave the output channel.
    typedef struct packed {
        logic        kind;
        logic [7:0]  index;
        logic [31:0] value;
        logic [7:0]  n_entries;
        logic [7:0]  loop_pos;
        logic [7:0]  rel_pos;
        logic        final_flag;
    } t_parse_result;

    // Receiver behaviour for one stretch of cycles.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT_STALL,
        RX_HEAVY_STALL,
        RX_TOGGLE
    } t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_code   = '0;
    logic        i_char_valid  = 1'b0;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic        o_kind;
    logic [7:0]  o_entry_index;
    logic signed [31:0] o_entry_value;
    logic [7:0]  o_entry_count;
    logic [7:0]  o_loop_position;
    logic [7:0]  o_release_position;
    logic        o_final_result;

    macro_text_value_parser dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_char_code        (i_char_code),
        .i_char_valid       (i_char_valid),
        .i_end_of_text      (i_end_of_text),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_entry_index      (o_entry_index),
        .o_entry_value      (o_entry_value),
        .o_entry_count      (o_entry_count),
        .o_loop_position    (o_loop_position),
        .o_release_position (o_release_position),
        .o_final_result     (o_final_result)
    );

    // Characters waiting to be offered, and results still owed by the block.
    t_text_char    text_chars [$];
    t_parse_result awaited_results [$];

    int chars_issued   = 0;
    int chars_accepted = 0;
    int results_seen   = 0;
    int fail_count     = 0;

    // Register copies as the block should hold them.
    logic signed [31:0] cfg_min  = 32'sh8000_0000;
    logic signed [31:0] cfg_max  = 32'sh7FFF_FFFF;
    logic               cfg_flip = 1'b0;

    // Parser state: number under construction, entry count and the two marks.
    logic [30:0] acc_mag     = '0;
    logic        acc_neg     = 1'b0;
    logic        acc_digits  = 1'b0;
    logic        acc_flip    = 1'b0;
    logic [7:0]  num_entries = '0;
    logic [7:0]  loop_at     = mtvp_pkg::NO_MARK;
    logic [7:0]  release_at  = mtvp_pkg::NO_MARK;

    // Sender burst control and receiver stall control.
    int            burst_left  = 1;
    int            gap_left    = 0;
    t_text_char    next_char;
    t_rx_mode      rx_mode     = RX_FREE;
    int            rx_left     = 0;
    int            hold_cycles = 0;
    bit            hold_done   = 1'b0;
    t_parse_result want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clamp the pending number, apply the flip mark and queue it as an entry.
    function automatic void emit_entry();
        longint        v;
        t_parse_result r;
        v = acc_neg ? -longint'(acc_mag) : longint'(acc_mag);
        if (v < longint'(cfg_min)) v = longint'(cfg_min);
        if (v > longint'(cfg_max)) v = longint'(cfg_max);
        r = '0;
        r.kind  = mtvp_pkg::KIND_ENTRY;
        r.index = num_entries;
        r.value = v[31:0];
        if (acc_flip) r.value = r.value ^ mtvp_pkg::FLIP_BIT;
        awaited_results.push_back(r);
        num_entries = num_entries + 8'd1;
        acc_mag     = '0;
        acc_neg     = 1'b0;
        acc_digits  = 1'b0;
        acc_flip    = 1'b0;
    endfunction

    // Work out the results that one accepted character causes.
    function automatic void predict_parse(input logic [7:0] ch, input logic cv,
                                          input logic eot);
        longint        grown;
        int            first_new;
        t_parse_result r;
        first_new = awaited_results.size();
        if (cv && num_entries < mtvp_pkg::MAX_ENTRIES) begin
            if (ch >= mtvp_pkg::CH_ZERO && ch <= mtvp_pkg::CH_NINE) begin
                grown = longint'(acc_mag) * 10 + longint'(ch - mtvp_pkg::CH_ZERO);
                acc_mag = (grown > longint'(mtvp_pkg::MAG_SAT)) ? mtvp_pkg::MAG_SAT
                                                                : grown[30:0];
                acc_digits = 1'b1;
            end else if (ch == mtvp_pkg::CH_MINUS) begin
                if (!acc_digits) begin
                    acc_digits = 1'b1;
                    acc_neg    = 1'b1;
                end
            end else if (ch == mtvp_pkg::CH_AT) begin
                if (cfg_flip) acc_flip = 1'b1;
            end else if (ch == mtvp_pkg::CH_SPACE || ch == mtvp_pkg::CH_BAR ||
                         ch == mtvp_pkg::CH_SLASH) begin
                if (acc_digits) emit_entry();
                if (ch == mtvp_pkg::CH_BAR && loop_at == mtvp_pkg::NO_MARK)
                    loop_at = num_entries;
                if (ch == mtvp_pkg::CH_SLASH && release_at == mtvp_pkg::NO_MARK)
                    release_at = num_entries;
            end
        end
        // End of text: flush what is pending, report the summary and start afresh.
        if (eot) begin
            if (acc_digits && num_entries < mtvp_pkg::MAX_ENTRIES) emit_entry();
            r = '0;
            r.kind      = mtvp_pkg::KIND_SUMMARY;
            r.n_entries = num_entries;
            r.loop_pos  = loop_at;
            r.rel_pos   = release_at;
            awaited_results.push_back(r);
            acc_mag     = '0;
            acc_neg     = 1'b0;
            acc_digits  = 1'b0;
            acc_flip    = 1'b0;
            num_entries = '0;
            loop_at     = mtvp_pkg::NO_MARK;
            release_at  = mtvp_pkg::NO_MARK;
        end
        if (awaited_results.size() > first_new)
            awaited_results[awaited_results.size() - 1].final_flag = 1'b1;
    endfunction

    // Input driver: bursts of transfers with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_parse(i_char_code, i_char_valid, i_end_of_text);
                chars_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (text_chars.size() > 0) begin
                    next_char = text_chars.pop_front();
                    i_valid       <= 1'b1;
                    i_char_code   <= next_char.code;
                    i_char_valid  <= next_char.valid;
                    i_end_of_text <= next_char.eot;
                    burst_left--;
                    if (burst_left <= 0) begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output receiver: a stall pattern of its own, plus one long hold-off
    // so that the internal queue fills and the input is stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 100) begin
            hold_done   = 1'b1;
            hold_cycles = 400;
            i_ready <= 1'b0;
        end else begin
            if (rx_left <= 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 80);
            end
            rx_left--;
            case (rx_mode)
                RX_FREE:        i_ready <= 1'b1;
                RX_LIGHT_STALL: i_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY_STALL: i_ready <= ($urandom_range(0, 3) == 0);
                default:        i_ready <= ~i_ready;
            endcase
        end
    end

    // Result monitor: each transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result: kind %0d index %0d value %0d",
                             o_kind, o_entry_index, o_entry_value);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_kind !== want.kind || o_entry_index !== want.index ||
                    o_entry_value !== want.value || o_entry_count !== want.n_entries ||
                    o_loop_position !== want.loop_pos ||
                    o_release_position !== want.rel_pos ||
                    o_final_result !== want.final_flag) begin
                    if (fail_count < 10) begin
                        $write("mismatch (expected/actual): kind %0d/%0d index %0d/%0d",
                               want.kind, o_kind, want.index, o_entry_index);
                        $write(" value %0d/%0d count %0d/%0d",
                               $signed(want.value), o_entry_value,
                               want.n_entries, o_entry_count);
                        $display(" loop %0d/%0d release %0d/%0d last %0d/%0d",
                                 want.loop_pos, o_loop_position,
                                 want.rel_pos, o_release_position,
                                 want.final_flag, o_final_result);
                    end
                    fail_count++;
                end
            end
        end
    end

    task automatic push_char(input logic [7:0] code, input logic cv, input logic eot);
        t_text_char c;
        c.code  = code;
        c.valid = cv;
        c.eot   = eot;
        text_chars.push_back(c);
        chars_issued++;
    endtask

    task automatic push_word(input string s);
        for (int k = 0; k < s.len(); k++) push_char(s[k], 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 2))
            0:       return mtvp_pkg::CH_SPACE;
            1:       return mtvp_pkg::CH_BAR;
            default: return mtvp_pkg::CH_SLASH;
        endcase
    endfunction

    // A random byte and a random decimal digit character.
    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] any_digit();
        return mtvp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // APB write: setup cycle, then access cycle until pready is seen.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mtvp_pkg::REG_MIN_VALUE:   cfg_min  = data;
            mtvp_pkg::REG_MAX_VALUE:   cfg_max  = data;
            mtvp_pkg::REG_FLIP_ENABLE: cfg_flip = data[0];
            default:                   ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                              input logic flip);
        reg_write(mtvp_pkg::REG_MIN_VALUE, lo);
        reg_write(mtvp_pkg::REG_MAX_VALUE, hi);
        reg_write(mtvp_pkg::REG_FLIP_ENABLE, {31'd0, flip});
    endtask

    // Wait until every character has gone in and every result has come out,
    // then give an item that causes no result time to pass through.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (chars_accepted != chars_issued || awaited_results.size() != 0);
        repeat (5) @(posedge i_clk);
    endtask

    // A well-formed macro text with random numbers, marks and a little noise.
    task automatic random_text();
        int n_tok;
        int n_dig;
        int flip_pos;
        n_tok = $urandom_range(0, 12);
        for (int t = 0; t < n_tok; t++) begin
            if ($urandom_range(0, 7) == 0) push_char(any_byte(), 1'b1, 1'b0);
            if ($urandom_range(0, 9) == 0) push_char(any_byte(), 1'b0, 1'b0);
            flip_pos = $urandom_range(0, 5);
            if (flip_pos == 0) push_char(mtvp_pkg::CH_AT, 1'b1, 1'b0);
            if ($urandom_range(0, 3) == 0) push_char(mtvp_pkg::CH_MINUS, 1'b1, 1'b0);
            // Mostly short numbers; now and then one long enough to saturate.
            n_dig = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 13)
                                                 : $urandom_range(0, 4);
            for (int d = 0; d < n_dig; d++)
                push_char(any_digit(), 1'b1, 1'b0);
            if ($urandom_range(0, 9) == 0) push_char(mtvp_pkg::CH_MINUS, 1'b1, 1'b0);
            if (flip_pos == 1) push_char(mtvp_pkg::CH_AT, 1'b1, 1'b0);
            push_char(pick_separator(), 1'b1, 1'b0);
            if ($urandom_range(0, 7) == 0) push_char(pick_separator(), 1'b1, 1'b0);
        end
        // The final item may itself carry a character.
        case ($urandom_range(0, 3))
            0:       push_char(any_byte(), 1'b0, 1'b1);
            1:       push_char(any_digit(), 1'b1, 1'b1);
            2:       push_char(pick_separator(), 1'b1, 1'b1);
            default: push_char(any_byte(), 1'b1, 1'b1);
        endcase
    endtask

    // A text that fills the entry list; the separator that closes the last
    // entry records a mark which then reads as none, and all later
    // characters are ignored.
    task automatic full_text();
        logic [7:0] late_sep;
        logic [7:0] early_sep;
        int         early_at;
        late_sep  = ($urandom_range(0, 1) == 1) ? mtvp_pkg::CH_BAR : mtvp_pkg::CH_SLASH;
        early_sep = (late_sep == mtvp_pkg::CH_BAR) ? mtvp_pkg::CH_SLASH : mtvp_pkg::CH_BAR;
        early_at  = $urandom_range(0, 253);
        for (int k = 0; k < 255; k++) begin
            push_char(any_digit(), 1'b1, 1'b0);
            if (k == 254)          push_char(late_sep, 1'b1, 1'b0);
            else if (k == early_at) push_char(early_sep, 1'b1, 1'b0);
            else                   push_char(mtvp_pkg::CH_SPACE, 1'b1, 1'b0);
        end
        push_word("8|/@-3 ");
        push_char(mtvp_pkg::CH_NINE, 1'b1, 1'b1);
    endtask

    // Main sequence: reset, directed text, then random phases at several settings.
    initial begin
        int target;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: saturated negative flipped number closed by a bar, a lone
        // minus closed by a slash, an ignored letter, a number flushed by the
        // final item, an empty item and a summary-only text.
        reg_write(mtvp_pkg::REG_FLIP_ENABLE, 32'd1);
        push_word("-@99999999999|");
        push_word("--/");
        push_word("A");
        push_word("7");
        push_char(mtvp_pkg::CH_ZERO + 8'd5, 1'b1, 1'b1);
        push_char(8'hFF, 1'b0, 1'b0);
        push_char(8'h00, 1'b0, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_config(-32'sd1000, 32'sd1000, 1'b1);
                1: set_config(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
                2: set_config(32'sd10, -32'sd10, 1'b1);
                3: set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
                4: set_config(32'h8000_0000, 32'h8000_0000, 1'b0);
                5: set_config(-$urandom_range(0, 100000), $urandom_range(0, 100000),
                              1'($urandom_range(0, 1)));
                default: set_config(32'd0, 32'h7FFF_FFFF, 1'b1);
            endcase
            target = chars_issued + 150;
            while (chars_issued < target) random_text();
            if (phase == 6) full_text();
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && awaited_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
